[sv/mst_pkg.sv]
package mst_pkg;

    localparam int unsigned TRACKS_DEF = 16;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'd0,
        ST_INIT    = 4'd1,
        ST_TAKEOFF = 4'd2,
        ST_SEARCH  = 4'd3,
        ST_ACQ     = 4'd4,
        ST_TRACK   = 4'd5,
        ST_LOST    = 4'd6,
        ST_RETURN  = 4'd7,
        ST_LANDED  = 4'd8,
        ST_ABORT   = 4'd9
    } t_mstate;

    localparam logic [2:0] MODE_START  = 3'd0;
    localparam logic [2:0] MODE_ABORT  = 3'd1;
    localparam logic [2:0] MODE_SELECT = 3'd2;
    localparam logic [2:0] MODE_DETECT = 3'd3;
    localparam logic [2:0] MODE_FRAME  = 3'd4;
    localparam logic [2:0] MODE_TICK   = 3'd5;

    localparam logic [2:0] REG_TAKEOFF = 3'd0;
    localparam logic [2:0] REG_CONF    = 3'd1;
    localparam logic [2:0] REG_CLASS   = 3'd2;
    localparam logic [2:0] REG_CONFIRM = 3'd3;
    localparam logic [2:0] REG_LOSS    = 3'd4;
    localparam logic [2:0] REG_TIMEOUT = 3'd5;
    localparam logic [2:0] REG_HOME    = 3'd6;

    typedef struct packed {
        logic [2:0]         mode;
        logic [15:0]        trk_id;
        logic [3:0]         class_id;
        logic [7:0]         confidence;
        logic [15:0]        altitude_dm;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
    } t_in_item;

    typedef struct packed {
        logic [3:0] mission_state;
        logic       mission_active;
        logic       confirmed_present;
        logic       selected_valid;
        logic       table_full_drop;
    } t_out_item;

    typedef struct packed {
        logic [15:0] takeoff_height_dm;
        logic [7:0]  confidence_min;
        logic [15:0] class_mask;
        logic [7:0]  confirm_frames;
        logic [19:0] loss_ticks;
        logic [31:0] timeout_ticks;
        logic [31:0] home_radius_sq;
    } t_cfg;

endpackage

[sv/mst_sqmul.sv]
// Shared 32x32 unsigned multiplier, one product registered per cycle.
module mst_sqmul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);
    logic [63:0] r_p;
    always_ff @(posedge i_clk) begin
        r_p <= {32'd0, i_a} * {32'd0, i_b};
    end
    assign o_p = r_p;
endmodule

[sv/mission_sequencer_with_track_table.sv]
// Sequence from accept to result: a table walk, an apply step, a second walk for the
//   status flags, an output step. A tick while returning adds the steps SQ_X, SQ_Y,
//   SQ_ACC and HOME for two squares through the shared multiplier.
// Flow: one item at a time; the next is accepted in the cycle after the result is
//   registered, which waits while the receiver stalls.
// Reset (synchronous, active low): state idle, time and positions zero, table empty.
module mission_sequencer_with_track_table #(
    parameter int unsigned TRACKS = mst_pkg::TRACKS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  mst_pkg::t_in_item   i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output mst_pkg::t_out_item  o_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    localparam int unsigned IW = (TRACKS > 1) ? $clog2(TRACKS) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_APPLY, S_SQ_X, S_SQ_Y, S_SQ_ACC, S_HOME, S_OUT
    } t_seq;

    t_seq r_seq;
    mst_pkg::t_cfg r_cfg;
    mst_pkg::t_in_item r_in;
    mst_pkg::t_mstate r_st;
    logic [31:0] r_now, r_mstart, r_tstart;
    logic signed [31:0] r_hx, r_hy, r_cx, r_cy;
    logic [16:0] r_sel;
    logic [TRACKS-1:0] r_valid;
    logic [15:0] r_etrack [TRACKS];
    logic [7:0]  r_eframes [TRACKS];
    logic [31:0] r_eseen [TRACKS];
    logic [IW-1:0] r_idx;
    // second walk after the update only gathers status flags
    logic r_post;
    // scan results
    logic r_hit, r_free_found, r_conf, r_selv, r_selfound;
    logic [IW-1:0] r_hit_idx, r_free_idx;
    logic r_drop;
    logic [63:0] r_sx;
    logic [31:0] r_ma, r_mb;
    logic [63:0] w_prod;
    logic r_ovalid;
    mst_pkg::t_out_item r_out;

    mst_sqmul u_mul (.i_clk(i_clk), .i_a(r_ma), .i_b(r_mb), .o_p(w_prod));

    assign o_stall = !i_rst_n || (r_seq != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_item = r_out;
    assign o_cfg_ready = 1'b1;

    logic [IW-1:0] w_i;
    logic [31:0] w_age;
    logic [20:0] w_lim;
    logic w_vld, w_stale, w_cls_ok;
    logic [32:0] w_dx, w_dy;
    logic [31:0] w_ax, w_ay;
    logic [64:0] w_sum;
    logic w_out_go, w_home_chk;
    assign w_i = r_idx;
    assign w_age = r_now - r_eseen[w_i];
    assign w_lim = {r_cfg.loss_ticks, 1'b0};
    assign w_vld = r_valid[w_i];
    // on frame end, stale entries are dropped before all other checks
    assign w_stale = w_vld && !r_post && (r_in.mode == mst_pkg::MODE_FRAME)
                     && ({1'b0, w_age} > {12'd0, w_lim});
    assign w_cls_ok = r_cfg.class_mask[r_in.class_id]
                      && (r_in.confidence >= r_cfg.confidence_min);
    assign w_dx = {r_cx[31], r_cx} - {r_hx[31], r_hx};
    assign w_dy = {r_cy[31], r_cy} - {r_hy[31], r_hy};
    assign w_ax = w_dx[32] ? 32'(-w_dx) : w_dx[31:0];
    assign w_ay = w_dy[32] ? 32'(-w_dy) : w_dy[31:0];
    assign w_sum = {1'b0, r_sx} + {1'b0, w_prod};
    assign w_out_go = (r_seq == S_OUT) && (!r_ovalid || !i_stall);
    assign w_home_chk = (r_in.mode == mst_pkg::MODE_TICK) && (r_st == mst_pkg::ST_RETURN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{takeoff_height_dm: 16'd500, confidence_min: 8'd179,
                       class_mask: 16'd3, confirm_frames: 8'd3,
                       loss_ticks: 20'd100, timeout_ticks: 32'd18000,
                       home_radius_sq: 32'd100};
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mst_pkg::REG_TAKEOFF: r_cfg.takeoff_height_dm <= i_cfg_data[15:0];
                mst_pkg::REG_CONF:    r_cfg.confidence_min <= i_cfg_data[7:0];
                mst_pkg::REG_CLASS:   r_cfg.class_mask <= i_cfg_data[15:0];
                mst_pkg::REG_CONFIRM: r_cfg.confirm_frames <= i_cfg_data[7:0];
                mst_pkg::REG_LOSS:    r_cfg.loss_ticks <= i_cfg_data[19:0];
                mst_pkg::REG_TIMEOUT: r_cfg.timeout_ticks <= i_cfg_data;
                mst_pkg::REG_HOME:    r_cfg.home_radius_sq <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // leaving tracking clears the selection
    function automatic logic [16:0] sel_after(input mst_pkg::t_mstate cur,
                                              input mst_pkg::t_mstate nxt,
                                              input logic [16:0] sel);
        return (cur == mst_pkg::ST_TRACK && nxt != mst_pkg::ST_TRACK) ? 17'd0 : sel;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= S_IDLE;
            r_st <= mst_pkg::ST_IDLE;
            r_now <= '0; r_mstart <= '0; r_tstart <= '0;
            r_hx <= '0; r_hy <= '0; r_cx <= '0; r_cy <= '0;
            r_sel <= '0;
            r_valid <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_out_go) r_ovalid <= 1'b1;
            else if (!i_stall) r_ovalid <= 1'b0;
            unique case (r_seq)
                S_IDLE: begin
                    if (i_valid) begin
                        r_in <= i_item;
                        r_idx <= '0;
                        r_post <= 1'b0;
                        r_hit <= 1'b0; r_free_found <= 1'b0; r_conf <= 1'b0;
                        r_selv <= 1'b0; r_selfound <= 1'b0; r_drop <= 1'b0;
                        r_hit_idx <= '0; r_free_idx <= '0;
                        r_seq <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // walk one entry per cycle: lookup, free slot, stale sweep
                    if (w_stale) begin
                        r_valid[w_i] <= 1'b0;
                    end else if (w_vld) begin
                        if (r_etrack[w_i] == r_in.trk_id && !r_hit) begin
                            r_hit <= 1'b1; r_hit_idx <= w_i;
                        end
                        if (r_eframes[w_i] >= r_cfg.confirm_frames) r_conf <= 1'b1;
                        if (r_sel[16] && r_etrack[w_i] == r_sel[15:0]
                            && !r_selfound) begin
                            r_selfound <= 1'b1;
                            r_selv <= (w_age < {12'd0, r_cfg.loss_ticks});
                        end
                    end
                    if (!w_vld && !r_free_found) begin
                        r_free_found <= 1'b1; r_free_idx <= w_i;
                    end
                    if (r_idx == IW'(TRACKS - 1)) r_seq <= r_post ? S_OUT : S_APPLY;
                    else r_idx <= r_idx + IW'(1);
                end
                S_APPLY: begin
                    r_seq <= w_home_chk ? S_SQ_X : S_SCAN;
                    r_idx <= '0; r_post <= 1'b1;
                    r_conf <= 1'b0; r_selv <= 1'b0; r_selfound <= 1'b0;
                    unique case (r_in.mode)
                        mst_pkg::MODE_START: begin
                            r_hx <= r_in.pos_x; r_hy <= r_in.pos_y;
                            r_cx <= r_in.pos_x; r_cy <= r_in.pos_y;
                            r_sel <= sel_after(r_st, mst_pkg::ST_INIT, r_sel);
                            r_st <= mst_pkg::ST_INIT;
                            r_mstart <= r_now;
                        end
                        mst_pkg::MODE_ABORT: begin
                            r_sel <= sel_after(r_st, mst_pkg::ST_ABORT, r_sel);
                            r_st <= mst_pkg::ST_ABORT;
                        end
                        mst_pkg::MODE_SELECT: begin
                            if (r_hit) begin
                                r_sel <= {1'b1, r_in.trk_id};
                                if (r_st == mst_pkg::ST_ACQ) begin
                                    r_st <= mst_pkg::ST_TRACK;
                                    r_tstart <= r_now;
                                end
                            end
                        end
                        mst_pkg::MODE_DETECT: begin
                            if (w_cls_ok) begin
                                if (r_hit) begin
                                    if (r_eframes[r_hit_idx] != 8'hFF)
                                        r_eframes[r_hit_idx] <= r_eframes[r_hit_idx] + 8'd1;
                                    r_eseen[r_hit_idx] <= r_now;
                                end else if (r_free_found) begin
                                    r_valid[r_free_idx] <= 1'b1;
                                    r_etrack[r_free_idx] <= r_in.trk_id;
                                    r_eframes[r_free_idx] <= 8'd1;
                                    r_eseen[r_free_idx] <= r_now;
                                end else begin
                                    r_drop <= 1'b1;
                                end
                            end
                        end
                        mst_pkg::MODE_FRAME: begin
                            priority if (r_st == mst_pkg::ST_SEARCH) begin
                                if (r_conf) r_st <= mst_pkg::ST_ACQ;
                            end else if (r_st == mst_pkg::ST_TRACK) begin
                                if (!r_selv) begin
                                    r_st <= mst_pkg::ST_LOST; r_sel <= '0;
                                end
                            end else if (r_st == mst_pkg::ST_LOST) begin
                                if (r_selv) r_st <= mst_pkg::ST_TRACK;
                                else if ({1'b0, r_now - r_tstart} > {12'd0, w_lim})
                                    r_st <= mst_pkg::ST_RETURN;
                            end else begin
                            end
                        end
                        mst_pkg::MODE_TICK: begin
                            r_now <= r_now + 32'd1;
                            r_cx <= r_in.pos_x; r_cy <= r_in.pos_y;
                            priority if (r_st == mst_pkg::ST_INIT) begin
                                r_st <= mst_pkg::ST_TAKEOFF;
                            end else if (r_st == mst_pkg::ST_TAKEOFF) begin
                                if (({1'b0, r_in.altitude_dm, 3'd0}
                                     + {3'd0, r_in.altitude_dm, 1'b0})
                                    >= ({1'b0, r_cfg.takeoff_height_dm, 3'd0}
                                        + {4'd0, r_cfg.takeoff_height_dm}))
                                    r_st <= mst_pkg::ST_SEARCH;
                            end else if (r_st == mst_pkg::ST_SEARCH
                                         || r_st == mst_pkg::ST_TRACK) begin
                                if (r_now + 32'd1 - r_mstart > r_cfg.timeout_ticks) begin
                                    r_sel <= sel_after(r_st, mst_pkg::ST_RETURN, r_sel);
                                    r_st <= mst_pkg::ST_RETURN;
                                end
                            end else begin
                            end
                        end
                        default: ;
                    endcase
                end
                S_SQ_X: begin
                    r_seq <= S_SQ_Y;
                end
                S_SQ_Y: begin
                    r_seq <= S_SQ_ACC;
                end
                S_SQ_ACC: begin
                    r_sx <= w_prod;
                    r_seq <= S_HOME;
                end
                S_HOME: begin
                    if (!w_sum[64] && w_sum[63:0] < {32'd0, r_cfg.home_radius_sq})
                        r_st <= mst_pkg::ST_LANDED;
                    r_seq <= S_SCAN;
                end
                S_OUT: begin
                    if (w_out_go) r_seq <= S_IDLE;
                end
                default: r_seq <= S_IDLE;
            endcase
        end
    end

    // multiplier operand select: |dx| then |dy|
    always_ff @(posedge i_clk) begin
        r_ma <= (r_seq == S_SQ_Y) ? w_ay : w_ax;
        r_mb <= (r_seq == S_SQ_Y) ? w_ay : w_ax;
    end

    always_ff @(posedge i_clk) begin
        if (w_out_go) begin
            r_out.mission_state <= r_st;
            r_out.mission_active <= !(r_st == mst_pkg::ST_IDLE
                                      || r_st == mst_pkg::ST_LANDED
                                      || r_st == mst_pkg::ST_ABORT);
            r_out.confirmed_present <= r_conf;
            r_out.selected_valid <= r_selv;
            r_out.table_full_drop <= r_drop;
        end
    end
endmodule

[sv/mst_checker.sv]
module mst_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input mst_pkg::t_out_item o_item
);
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall) else $error("not busy after accept");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_item))) else $error("output dropped");
    a_state_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.mission_state <= mst_pkg::ST_ABORT)) else $error("bad state");
    a_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.mission_state == mst_pkg::ST_IDLE) |-> !o_item.mission_active)
        else $error("idle but active");
endmodule

bind mission_sequencer_with_track_table mst_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item)
);

[bench/mission_sequencer_with_track_table_tb.sv]
module mission_sequencer_with_track_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    mst_pkg::t_in_item   i_item;
    logic                o_valid;
    logic                i_stall;
    mst_pkg::t_out_item  o_item;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [2:0]          i_cfg_index;
    logic [31:0]         i_cfg_data;

    mission_sequencer_with_track_table u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_item      (o_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    localparam int NTRK = mst_pkg::TRACKS_DEF;

    // predictor copy of the block
    mst_pkg::t_cfg     cfg;
    mst_pkg::t_mstate  m_state;
    logic [31:0] m_now, m_start_tick, m_track_tick;
    logic signed [31:0] m_home_x, m_home_y, m_cur_x, m_cur_y;
    logic        m_ent_valid [NTRK];
    logic [15:0] m_ent_id [NTRK];
    logic [7:0]  m_ent_frames [NTRK];
    logic [31:0] m_ent_seen [NTRK];
    logic        m_sel_on;
    logic [15:0] m_sel_id;

    mst_pkg::t_in_item   pending_items[$];
    mst_pkg::t_out_item  expected_status[$];
    int          mismatches = 0;
    int          fails = 0;

    // receiver hold-off control
    bit          hold_long = 0;
    int          hold_count = 0;
    int          burst_left = 0;
    int          gap_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void model_reset();
        cfg = '{16'd500, 8'd179, 16'd3, 8'd3, 20'd100, 32'd18000, 32'd100};
        m_state = mst_pkg::ST_IDLE;
        m_now = 0; m_start_tick = 0; m_track_tick = 0;
        m_home_x = 0; m_home_y = 0; m_cur_x = 0; m_cur_y = 0;
        m_sel_on = 0; m_sel_id = 0;
        for (int i = 0; i < NTRK; i++) m_ent_valid[i] = 0;
    endfunction

    function automatic void model_cfg(logic [2:0] idx, logic [31:0] d);
        case (idx)
            mst_pkg::REG_TAKEOFF: cfg.takeoff_height_dm = d[15:0];
            mst_pkg::REG_CONF:    cfg.confidence_min = d[7:0];
            mst_pkg::REG_CLASS:   cfg.class_mask = d[15:0];
            mst_pkg::REG_CONFIRM: cfg.confirm_frames = d[7:0];
            mst_pkg::REG_LOSS:    cfg.loss_ticks = d[19:0];
            mst_pkg::REG_TIMEOUT: cfg.timeout_ticks = d;
            mst_pkg::REG_HOME:    cfg.home_radius_sq = d;
            default: ;
        endcase
    endfunction

    function automatic void goto_state(mst_pkg::t_mstate nxt);
        if (m_state == mst_pkg::ST_TRACK) m_sel_on = 0;
        m_state = nxt;
    endfunction

    function automatic int lookup_track(logic [15:0] id);
        for (int i = 0; i < NTRK; i++)
            if (m_ent_valid[i] && m_ent_id[i] == id) return i;
        return -1;
    endfunction

    function automatic bit any_confirmed();
        for (int i = 0; i < NTRK; i++)
            if (m_ent_valid[i] && m_ent_frames[i] >= cfg.confirm_frames) return 1;
        return 0;
    endfunction

    function automatic bit selection_ok();
        int k;
        logic [31:0] age;
        if (!m_sel_on) return 0;
        k = lookup_track(m_sel_id);
        if (k < 0) return 0;
        age = m_now - m_ent_seen[k];
        return age < {12'd0, cfg.loss_ticks};
    endfunction

    function automatic bit near_home();
        logic [63:0] dx, dy, sx, sy;
        logic [64:0] s;
        dx = ($signed(64'(m_cur_x)) > $signed(64'(m_home_x)))
             ? $signed(64'(m_cur_x)) - $signed(64'(m_home_x))
             : $signed(64'(m_home_x)) - $signed(64'(m_cur_x));
        dy = ($signed(64'(m_cur_y)) > $signed(64'(m_home_y)))
             ? $signed(64'(m_cur_y)) - $signed(64'(m_home_y))
             : $signed(64'(m_home_y)) - $signed(64'(m_cur_y));
        sx = dx * dx;
        sy = dy * dy;
        s = {1'b0, sx} + {1'b0, sy};
        if (s[64]) return 0;
        return s[63:0] < {32'd0, cfg.home_radius_sq};
    endfunction

    function automatic mst_pkg::t_out_item predict_status(mst_pkg::t_in_item it);
        mst_pkg::t_out_item r;
        bit drop;
        int k;
        logic [32:0] lim;
        drop = 0;
        lim = {13'd0, cfg.loss_ticks} << 1;
        case (it.mode)
            mst_pkg::MODE_START: begin
                m_home_x = it.pos_x; m_home_y = it.pos_y;
                m_cur_x = it.pos_x; m_cur_y = it.pos_y;
                goto_state(mst_pkg::ST_INIT);
                m_start_tick = m_now;
            end
            mst_pkg::MODE_ABORT: goto_state(mst_pkg::ST_ABORT);
            mst_pkg::MODE_SELECT: begin
                if (lookup_track(it.trk_id) >= 0) begin
                    m_sel_on = 1; m_sel_id = it.trk_id;
                    if (m_state == mst_pkg::ST_ACQ) begin
                        goto_state(mst_pkg::ST_TRACK);
                        m_track_tick = m_now;
                    end
                end
            end
            mst_pkg::MODE_DETECT: begin
                if (cfg.class_mask[it.class_id] && it.confidence >= cfg.confidence_min) begin
                    k = lookup_track(it.trk_id);
                    if (k >= 0) begin
                        if (m_ent_frames[k] != 8'hff) m_ent_frames[k]++;
                        m_ent_seen[k] = m_now;
                    end else begin
                        k = 0;
                        while (k < NTRK && m_ent_valid[k]) k++;
                        if (k < NTRK) begin
                            m_ent_valid[k] = 1; m_ent_id[k] = it.trk_id;
                            m_ent_frames[k] = 1; m_ent_seen[k] = m_now;
                        end else drop = 1;
                    end
                end
            end
            mst_pkg::MODE_FRAME: begin
                for (int i = 0; i < NTRK; i++)
                    if (m_ent_valid[i] && {1'b0, m_now - m_ent_seen[i]} > lim)
                        m_ent_valid[i] = 0;
                if (m_state == mst_pkg::ST_SEARCH) begin
                    if (any_confirmed()) goto_state(mst_pkg::ST_ACQ);
                end else if (m_state == mst_pkg::ST_TRACK) begin
                    if (!selection_ok()) goto_state(mst_pkg::ST_LOST);
                end else if (m_state == mst_pkg::ST_LOST) begin
                    if (selection_ok()) goto_state(mst_pkg::ST_TRACK);
                    else if ({1'b0, m_now - m_track_tick} > lim)
                        goto_state(mst_pkg::ST_RETURN);
                end
            end
            mst_pkg::MODE_TICK: begin
                m_now++;
                m_cur_x = it.pos_x; m_cur_y = it.pos_y;
                if (m_state == mst_pkg::ST_INIT) goto_state(mst_pkg::ST_TAKEOFF);
                else if (m_state == mst_pkg::ST_TAKEOFF) begin
                    if (32'(it.altitude_dm) * 10 >= 32'(cfg.takeoff_height_dm) * 9)
                        goto_state(mst_pkg::ST_SEARCH);
                end else if (m_state == mst_pkg::ST_SEARCH || m_state == mst_pkg::ST_TRACK) begin
                    if (m_now - m_start_tick > cfg.timeout_ticks)
                        goto_state(mst_pkg::ST_RETURN);
                end else if (m_state == mst_pkg::ST_RETURN) begin
                    if (near_home()) goto_state(mst_pkg::ST_LANDED);
                end
            end
            default: ;
        endcase
        r.mission_state = m_state;
        r.mission_active = !(m_state == mst_pkg::ST_IDLE || m_state == mst_pkg::ST_LANDED ||
                             m_state == mst_pkg::ST_ABORT);
        r.confirmed_present = any_confirmed();
        r.selected_valid = selection_ok();
        r.table_full_drop = drop;
        return r;
    endfunction

    function automatic mst_pkg::t_in_item make_item(logic [2:0] md, logic [15:0] id);
        mst_pkg::t_in_item it;
        it.mode = md;
        it.trk_id = id;
        it.class_id = 4'($urandom_range(0, 15));
        it.confidence = 8'($urandom);
        it.altitude_dm = 16'($urandom);
        it.pos_x = $urandom;
        it.pos_y = $urandom;
        return it;
    endfunction

    function automatic void queue_item(mst_pkg::t_in_item it);
        pending_items = {pending_items, it};
        expected_status = {expected_status, predict_status(it)};
    endfunction

    // sender: bursts and gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_item <= '0;
        end else begin
            if (i_valid && !o_stall) void'(pending_items.pop_front());
            if (i_valid && o_stall) begin
                i_valid <= 1'b1;
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid <= 1'b0;
            end else begin
                if (pending_items.size() > 0) begin
                    i_valid <= 1'b1;
                    i_item <= pending_items[0];
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 20);
                    end else burst_left <= burst_left - 1;
                end else i_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern and result checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            hold_count <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_status.size() == 0) begin
                    fails++;
                    if (mismatches++ < 10)
                        $display("unexpected status item %p", o_item);
                end else begin
                    mst_pkg::t_out_item e;
                    e = expected_status.pop_front();
                    if (e !== o_item) begin
                        fails++;
                        if (mismatches++ < 10)
                            $display("status mismatch: expected %p got %p", e, o_item);
                    end
                end
            end
            if (hold_long) begin
                i_stall <= 1'b1;
                hold_count <= hold_count + 1;
            end else begin
                hold_count <= 0;
                case ($urandom_range(0, 3))
                    0: i_stall <= ($urandom_range(0, 1) == 0);
                    1: i_stall <= ($urandom_range(0, 7) == 0);
                    default: i_stall <= 1'b0;
                endcase
            end
        end
    end

    task automatic wait_drained();
        while (pending_items.size() > 0 || expected_status.size() > 0 || i_valid)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] d);
        i_cfg_valid <= 1'b1; i_cfg_index <= idx; i_cfg_data <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        model_cfg(idx, d);
    endtask

    // a mission that opens with a start item, then random content including unused modes
    task automatic queue_mission(int len);
        mst_pkg::t_in_item it;
        logic [15:0] ids[4];
        for (int k = 0; k < 4; k++) ids[k] = 16'($urandom_range(0, 40));
        it = make_item(mst_pkg::MODE_START, 16'd0);
        if ($urandom_range(0, 1)) begin it.pos_x = 0; it.pos_y = 0; end
        queue_item(it);
        for (int n = 0; n < len; n++) begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 35) begin
                it = make_item(mst_pkg::MODE_DETECT, ids[$urandom_range(0, 3)]);
                if ($urandom_range(0, 3) != 0) begin
                    it.class_id = 4'($urandom_range(0, 1));
                    it.confidence = 8'($urandom_range(180, 255));
                end
            end else if (r < 50) it = make_item(mst_pkg::MODE_FRAME, 16'd0);
            else if (r < 58) it = make_item(mst_pkg::MODE_SELECT, ids[$urandom_range(0, 3)]);
            else if (r < 90) begin
                it = make_item(mst_pkg::MODE_TICK, 16'd0);
                if ($urandom_range(0, 2) == 0) it.altitude_dm = 16'hffff;
                if ($urandom_range(0, 2) != 0) begin
                    it.pos_x = m_home_x + $signed($urandom_range(0, 12)) - 6;
                    it.pos_y = m_home_y + $signed($urandom_range(0, 12)) - 6;
                end
            end else if (r < 92) it = make_item(mst_pkg::MODE_ABORT, 16'd0);
            else if (r < 94) it = make_item(3'(6 + $urandom_range(0, 1)), 16'($urandom));
            else it = make_item(3'($urandom_range(0, 5)), 16'($urandom));
            queue_item(it);
        end
    endtask

    task automatic random_phase(int count);
        int made;
        made = 0;
        while (made < count) begin
            int len;
            len = $urandom_range(20, 70);
            queue_mission(len);
            made += len + 1;
        end
    endtask

    initial begin
        mst_pkg::t_in_item it;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = mst_pkg::REG_TAKEOFF; i_cfg_data = '0;
        model_reset();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: mission walk, extremes, table overflow
        write_reg(mst_pkg::REG_LOSS, 32'd5);
        write_reg(mst_pkg::REG_CONFIRM, 32'd2);
        it = make_item(mst_pkg::MODE_START, 16'd0);
        it.pos_x = 32'sh7fffffff; it.pos_y = 32'sh80000000;
        queue_item(it);
        it = make_item(mst_pkg::MODE_TICK, 16'd0); queue_item(it);
        it = make_item(mst_pkg::MODE_TICK, 16'd0); it.altitude_dm = 16'hffff; queue_item(it);
        for (int k = 0; k < 17; k++) begin
            it = make_item(mst_pkg::MODE_DETECT, 16'(16'hffff - k));
            it.class_id = 4'd1; it.confidence = 8'hff; queue_item(it);
        end
        it = make_item(mst_pkg::MODE_DETECT, 16'hffff);
        it.class_id = 4'd0; it.confidence = 8'hff;
        queue_item(it);
        it = make_item(mst_pkg::MODE_FRAME, 16'd0); queue_item(it);
        it = make_item(mst_pkg::MODE_SELECT, 16'hffff); queue_item(it);
        it = make_item(3'd7, 16'hffff); queue_item(it);
        it = make_item(mst_pkg::MODE_ABORT, 16'd0); queue_item(it);
        wait_drained();

        // long receiver hold-off while sender keeps offering
        hold_long = 1;
        random_phase(60);
        while (hold_count < 400) @(posedge i_clk);
        hold_long = 0;
        wait_drained();

        // extremes of the registers
        write_reg(mst_pkg::REG_TAKEOFF, 32'hffff);
        write_reg(mst_pkg::REG_CONF, 32'd0);
        write_reg(mst_pkg::REG_CLASS, 32'hffff);
        write_reg(mst_pkg::REG_CONFIRM, 32'd0);
        write_reg(mst_pkg::REG_LOSS, 32'd0);
        write_reg(mst_pkg::REG_TIMEOUT, 32'hffffffff);
        write_reg(mst_pkg::REG_HOME, 32'hffffffff);
        random_phase(150);
        wait_drained();

        write_reg(mst_pkg::REG_TAKEOFF, 32'd0);
        write_reg(mst_pkg::REG_CONF, 32'd255);
        write_reg(mst_pkg::REG_CLASS, 32'd0);
        write_reg(mst_pkg::REG_CONFIRM, 32'd255);
        write_reg(mst_pkg::REG_LOSS, 32'hfffff);
        write_reg(mst_pkg::REG_TIMEOUT, 32'd1);
        write_reg(mst_pkg::REG_HOME, 32'd0);
        random_phase(100);
        wait_drained();

        write_reg(mst_pkg::REG_TAKEOFF, 32'd10);
        write_reg(mst_pkg::REG_CONF, 32'd100);
        write_reg(mst_pkg::REG_CLASS, 32'h3);
        write_reg(mst_pkg::REG_CONFIRM, 32'd1);
        write_reg(mst_pkg::REG_LOSS, 32'd8);
        write_reg(mst_pkg::REG_TIMEOUT, 32'd30);
        write_reg(mst_pkg::REG_HOME, 32'd50);
        random_phase(250);
        wait_drained();

        write_reg(mst_pkg::REG_CONFIRM, 32'd3);
        write_reg(mst_pkg::REG_LOSS, 32'd3);
        write_reg(mst_pkg::REG_TIMEOUT, 32'd60);
        random_phase(200);
        wait_drained();

        if (fails == 0) $display("mission_sequencer_with_track_table_tb passed");
        else $display("mission_sequencer_with_track_table_tb failed");
        $finish;
    end

    initial begin
        #5ms;
        $display("mission_sequencer_with_track_table_tb failed");
        $finish;
    end
endmodule

[sim.f]
sv/mst_pkg.sv
sv/mst_sqmul.sv
sv/mission_sequencer_with_track_table.sv
sv/mst_checker.sv
bench/mission_sequencer_with_track_table_tb.sv
